[rtl/message_ring_queue_overwrite_assert.svh]
// Assertion macros for the message ring queue.
`ifndef MESSAGE_RING_QUEUE_OVERWRITE_ASSERT_SVH
`define MESSAGE_RING_QUEUE_OVERWRITE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSGQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MSGQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/msgq_pkg.sv]
// Shared result codes and result word type for the message ring queue.
`timescale 1ns / 1ps
package msgq_pkg;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       dropped_oldest;
    logic       truncated;
  } result_t;

endpackage

[rtl/msgq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module msgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/msgq_out_stage.sv]
// Output register holding one result word until the receiver takes it.
`timescale 1ns / 1ps
module msgq_out_stage import msgq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    free,
  output logic    out_valid,
  output result_t res_out
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[rtl/message_ring_queue_overwrite.sv]
// Top level of the message ring queue that overwrites its oldest message.
//
// Input words carry an opcode: push one message byte, or pop the oldest
// message. Push bytes stream into the free slot; the byte flagged end of
// message commits it and returns one acknowledge word (dropped oldest,
// truncated). Bytes past SLOT_BYTES are dropped. A byte without end flag
// returns nothing. A pop returns the message one data word per byte, the
// final one flagged last, or a single empty word.
// Timing: an acknowledge or empty word is ready in the output register in
// the cycle after acceptance. A pop without stall first reads the length
// memory, then each byte is a registered read of the byte memory followed
// by the output register load. The block works on one input word at a time and
// takes the next one only when the output register is empty or read that cycle.
// Reset (synchronous, active low) empties the queue; memories need no
// clearing pass. A stalled receiver holds the output register; the pop
// sequence and the input wait.
`timescale 1ns / 1ps
`include "message_ring_queue_overwrite_assert.svh"
module message_ring_queue_overwrite import msgq_pkg::*; #(
  parameter int QUEUE_SLOTS = 8,
  parameter int SLOT_BYTES  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last_byte,
  output logic       out_dropped_oldest,
  output logic       out_truncated
);

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int DEPTH  = QUEUE_SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;
  logic [CNT_W-1:0]  bip_r, bip_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;

  logic              free;
  logic              acc, push, pop, empty, commit, drop, room, issue, last;
  logic [SLOT_W-1:0] ws_inc, rs_inc;
  logic              load;
  result_t           res, res_out;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        byte_rdata;
  logic [CNT_W-1:0]  len_rdata;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    return ADDR_W'(s) * ADDR_W'(SLOT_BYTES);
  endfunction

  assign in_ready = (state_r == ST_IDLE) && free;
  assign acc      = in_valid && in_ready;
  assign push     = acc && !in_opcode;
  assign pop      = acc && in_opcode;
  assign empty    = (rs_r == ws_r);
  assign room     = (bip_r < CNT_W'(SLOT_BYTES));
  assign commit   = push && in_end_of_message;
  assign ws_inc   = next_slot(ws_r);
  assign rs_inc   = next_slot(rs_r);
  assign drop     = (ws_inc == rs_r);
  assign issue    = (state_r == ST_POP) && !pend_r && free && (idx_r < len_r);
  assign last     = (idx_r == len_r);

  assign waddr = slot_base(ws_r) + ADDR_W'(bip_r);
  assign raddr = slot_base(rs_r) + ADDR_W'(idx_r);

  always_comb begin
    state_nxt = state_r;
    ws_nxt    = ws_r;
    rs_nxt    = rs_r;
    bip_nxt   = bip_r;
    ovf_nxt   = ovf_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    pend_nxt  = issue;
    load      = 1'b0;
    res       = '{kind: KIND_ACK, out_byte: 8'd0, last_byte: 1'b1,
                  dropped_oldest: 1'b0, truncated: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (push) begin
          if (room) begin
            bip_nxt = bip_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (commit) begin
            load               = 1'b1;
            res.dropped_oldest = drop;
            res.truncated      = ovf_r || !room;
            ws_nxt             = ws_inc;
            bip_nxt            = '0;
            ovf_nxt            = 1'b0;
            if (drop) begin
              rs_nxt = rs_inc;
            end
          end
        end else if (pop) begin
          if (empty) begin
            load     = 1'b1;
            res.kind = KIND_EMPTY;
          end else begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        len_nxt   = len_rdata;
        idx_nxt   = '0;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pend_r) begin
          load          = 1'b1;
          res.kind      = KIND_DATA;
          res.out_byte  = byte_rdata;
          res.last_byte = last;
          if (last) begin
            rs_nxt    = rs_inc;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ws_r    <= '0;
      rs_r    <= '0;
      bip_r   <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ws_r    <= ws_nxt;
      rs_r    <= rs_nxt;
      bip_r   <= bip_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    idx_r <= idx_nxt;
  end

  msgq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (push && room),
    .waddr (waddr),
    .wdata (in_data_byte),
    .re    (issue),
    .raddr (raddr),
    .rdata (byte_rdata)
  );

  msgq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (ws_r),
    .wdata (room ? bip_r + 1'b1 : bip_r),
    .re    (pop),
    .raddr (rs_r),
    .rdata (len_rdata)
  );

  msgq_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res),
    .out_ready (out_ready),
    .free      (free),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_kind           = res_out.kind;
  assign out_out_byte       = res_out.out_byte;
  assign out_last_byte      = res_out.last_byte;
  assign out_dropped_oldest = res_out.dropped_oldest;
  assign out_truncated      = res_out.truncated;

  `MSGQ_ASSERT_NOW(a_load_free, load, free, "result loaded over a held word")
  `MSGQ_ASSERT_NOW(a_pend_pop, pend_r, state_r == ST_POP, "byte read outside pop")
  `MSGQ_ASSERT_NOW(a_idx_range, state_r == ST_POP, idx_r <= len_r, "pop index past length")
  `MSGQ_ASSERT_NEXT(a_last_idle, load && res.kind == KIND_DATA && res.last_byte,
    state_r == ST_IDLE && !pend_r, "pop not closed after last byte")

endmodule

[test/tb_message_ring_queue_overwrite.sv]
// Testbench for the message ring queue: random push/pop traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_message_ring_queue_overwrite import msgq_pkg::*; ();

  localparam int QUEUE_SLOTS = 8;
  localparam int SLOT_BYTES  = 32;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       eom;
  } queue_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_opcode = OP_PUSH;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_last_byte;
  logic       out_dropped_oldest;
  logic       out_truncated;

  message_ring_queue_overwrite #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_out_byte      (out_out_byte),
    .out_last_byte     (out_last_byte),
    .out_dropped_oldest(out_dropped_oldest),
    .out_truncated     (out_truncated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state of the ring.
  logic [7:0] slot_data [QUEUE_SLOTS][SLOT_BYTES];
  int         slot_len  [QUEUE_SLOTS];
  int         wr_slot = 0;
  int         rd_slot = 0;
  int         fill_cnt = 0;
  bit         clip_seen = 1'b0;

  queue_cmd_t cmd_q[$];
  result_t    awaited_words[$];
  queue_cmd_t next_cmd;

  int errors = 0;
  int cycle_cnt = 0;
  int burst_cnt = 0;
  int gap_cnt = 0;
  int n_push = 0, n_pop = 0;
  int n_ack = 0, n_data = 0, n_empty = 0, n_drop = 0, n_trunc = 0;

  function automatic int next_slot_of(int s);
    return (s + 1 >= QUEUE_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic void ring_apply(logic op, logic [7:0] d, logic eom);
    result_t w;
    w = '0;
    if (op == OP_PUSH) begin
      if (fill_cnt < SLOT_BYTES) begin
        slot_data[wr_slot][fill_cnt] = d;
        fill_cnt++;
      end else begin
        clip_seen = 1'b1;
      end
      if (!eom) return;
      slot_len[wr_slot] = fill_cnt;
      w.kind = KIND_ACK;
      w.last_byte = 1'b1;
      w.truncated = clip_seen;
      wr_slot = next_slot_of(wr_slot);
      if (wr_slot == rd_slot) begin
        rd_slot = next_slot_of(rd_slot);
        w.dropped_oldest = 1'b1;
      end
      fill_cnt = 0;
      clip_seen = 1'b0;
      awaited_words.push_back(w);
    end else if (rd_slot == wr_slot) begin
      w.kind = KIND_EMPTY;
      w.last_byte = 1'b1;
      awaited_words.push_back(w);
    end else begin
      for (int i = 0; i < slot_len[rd_slot]; i++) begin
        w.kind = KIND_DATA;
        w.out_byte = slot_data[rd_slot][i];
        w.last_byte = (i + 1 == slot_len[rd_slot]);
        awaited_words.push_back(w);
      end
      rd_slot = next_slot_of(rd_slot);
    end
  endfunction

  function automatic void add_cmd(logic op, logic [7:0] d, logic eom);
    queue_cmd_t c;
    c.op = op;
    c.data = d;
    c.eom = eom;
    cmd_q.push_back(c);
  endfunction

  task automatic add_random_message(int pop_pct);
    int len;
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) len = $urandom_range(1, 6);
    else if (r < 18) len = $urandom_range(7, SLOT_BYTES);
    else len = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 8);
    for (int i = 0; i < len; i++) begin
      add_cmd(OP_PUSH, 8'($urandom), (i == len - 1));
      // interleave a pop with a message in flight
      if (i != len - 1 && $urandom_range(0, 99) < pop_pct / 4) add_cmd(OP_POP, 8'($urandom), 1'($urandom));
    end
  endtask

  // Sender: bursts of random length, random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ring_apply(in_opcode, in_data_byte, in_end_of_message);
        if (in_opcode == OP_PUSH) n_push++;
        else n_pop++;
      end
      if (!in_valid || in_ready) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_cmd.op;
          in_data_byte <= next_cmd.data;
          in_end_of_message <= next_cmd.eom;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(1, 24);
            gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each word, stall on a rotating pattern.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_out_byte, out_last_byte, out_dropped_oldest, out_truncated};
        case (got.kind)
          KIND_ACK: n_ack++;
          KIND_DATA: n_data++;
          default: n_empty++;
        endcase
        if (got.kind == KIND_ACK && got.dropped_oldest) n_drop++;
        if (got.kind == KIND_ACK && got.truncated) n_trunc++;
        if (awaited_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind=%0d byte=%02h last=%0b drop=%0b trunc=%0b",
                   $time, got.kind, got.out_byte, got.last_byte, got.dropped_oldest,
                   got.truncated);
        end else begin
          want = awaited_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d byte=%02h last=%0b drop=%0b trunc=%0b",
                     $time, want.kind, want.out_byte, want.last_byte, want.dropped_oldest,
                     want.truncated);
            $display("%0t:          actual   kind=%0d byte=%02h last=%0b drop=%0b trunc=%0b",
                     $time, got.kind, got.out_byte, got.last_byte, got.dropped_oldest,
                     got.truncated);
          end
        end
      end
      case ((cycle_cnt >> 8) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ((cycle_cnt % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, awaited_words.size());
      $display("tb_message_ring_queue_overwrite failed");
      $finish;
    end
  end

  initial begin
    int pop_pct;
    int total;
    add_cmd(OP_POP, 8'h00, 1'b0);
    add_cmd(OP_PUSH, 8'h00, 1'b1);
    add_cmd(OP_PUSH, 8'hFF, 1'b1);
    add_cmd(OP_POP, 8'hFF, 1'b1);
    add_cmd(OP_POP, 8'h00, 1'b0);
    add_cmd(OP_POP, 8'h00, 1'b0);
    add_cmd(OP_PUSH, 8'hA5, 1'b0);
    add_cmd(OP_POP, 8'h00, 1'b0);
    add_cmd(OP_PUSH, 8'h5A, 1'b1);
    add_cmd(OP_POP, 8'h00, 1'b0);
    // fill past capacity so the oldest gets overwritten
    for (int i = 1; i <= QUEUE_SLOTS; i++) add_cmd(OP_PUSH, 8'(i), 1'b1);
    add_cmd(OP_POP, 8'h00, 1'b0);
    add_cmd(OP_POP, 8'h00, 1'b0);

    total = cmd_q.size() + RANDOM_ITEMS;
    pop_pct = 30;
    while (cmd_q.size() < total) begin
      if ($urandom_range(0, 15) == 0) pop_pct = $urandom_range(10, 60);
      if ($urandom_range(0, 99) < pop_pct) add_cmd(OP_POP, 8'($urandom), 1'($urandom));
      else add_random_message(pop_pct);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_q.size() != 0 || in_valid || awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d push bytes, %0d pops; %0d acks (%0d overwrote oldest, %0d truncated),",
             n_push, n_pop, n_ack, n_drop, n_trunc);
    $display("     %0d data words, %0d empty replies, %0d errors", n_data, n_empty, errors);
    if (errors == 0) begin
      $display("tb_message_ring_queue_overwrite passed");
    end else begin
      $display("tb_message_ring_queue_overwrite failed");
    end
    $finish;
  end

endmodule
